/* hdl/crxmb_pkg.sv */
`timescale 1ns / 1ps

package crxmb_pkg;

    // Field widths of one frame
    localparam int ID_W     = 29;
    localparam int STD_ID_W = 11;
    localparam int KEY_W    = 30;
    localparam int DLC_W    = 4;
    localparam int DATA_W   = 64;

    // Number of key registers on the configuration port
    localparam int KEY_REGS = 4;

    // Configuration register indexes
    localparam logic [2:0] CFG_COUNT = 3'd0;
    localparam logic [2:0] CFG_KEY0  = 3'd1;
    localparam logic [2:0] CFG_KEY1  = 3'd2;
    localparam logic [2:0] CFG_KEY2  = 3'd3;
    localparam logic [2:0] CFG_KEY3  = 3'd4;

    // Item opcodes
    localparam logic OP_ROUTE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_NO_MATCH = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // Stored frame header
    typedef struct packed {
        logic               ide;
        logic [ID_W-1:0]    id;
        logic               rtr;
        logic [DLC_W-1:0]   dlc;
    } t_hdr;

    // One FIFO entry: header plus payload
    typedef struct packed {
        t_hdr               hdr;
        logic [DATA_W-1:0]  data;
    } t_entry;

endpackage

/* hdl/can_rx_id_router_mailbox_fifo_top.sv */
`timescale 1ns / 1ps
// A read goes from accept to the access state and then to the done state; a routed
// frame is first scanned against the enabled keys, then accesses the matching mailbox.
// One compare unit walks the key table one mailbox per cycle; an unmatched frame ends
// the scan without an access. The next item is taken once the result is loaded into
// the output register, so a stalled result holds off the next item. Reset is synchronous, active
// low: clears keys, pointers, fill and overflow counts; FIFO memory is not cleared.
module can_rx_id_router_mailbox_fifo_top #(
    parameter int MAILBOXES   = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [29:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [1:0]  i_read_mailbox,
    input  logic        i_frame_ide,
    input  logic [28:0] i_frame_id,
    input  logic        i_frame_rtr,
    input  logic [3:0]  i_frame_dlc,
    input  logic [63:0] i_frame_data,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_mailbox_index,
    output logic        o_out_ide,
    output logic [28:0] o_out_id,
    output logic        o_out_rtr,
    output logic [3:0]  o_out_dlc,
    output logic [63:0] o_out_data,
    output logic [4:0]  o_fill_level,
    output logic [15:0] o_overflow_count
);

    localparam int MB_W   = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int FW     = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH  = MAILBOXES * QUEUE_DEPTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EN_MAX = (MAILBOXES < crxmb_pkg::KEY_REGS) ? MAILBOXES
                                                              : crxmb_pkg::KEY_REGS;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_ACCESS = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [2:0]                  r_cfg_count;
    logic [crxmb_pkg::KEY_W-1:0] r_key [crxmb_pkg::KEY_REGS];

    // item registers
    logic              r_op;
    logic [1:0]        r_rmb;
    logic              r_mb_ok;
    crxmb_pkg::t_hdr   r_hdr;
    logic [63:0]       r_data;
    logic [2:0]        r_idx;
    logic [MB_W-1:0]   r_mb;

    // per-mailbox queue state
    logic [QW-1:0]     r_rp   [MAILBOXES];
    logic [QW-1:0]     r_wp   [MAILBOXES];
    logic [FW-1:0]     r_fill [MAILBOXES];
    logic [15:0]       r_ovf  [MAILBOXES];

    // result registers
    crxmb_pkg::t_status r_res_status;
    logic [1:0]         r_res_mbi;
    logic [FW-1:0]      r_res_fill;
    logic [15:0]        r_res_ovf;

    // output registers
    logic               r_out_valid;
    crxmb_pkg::t_status r_out_status;
    logic [1:0]         r_out_mbi;
    crxmb_pkg::t_hdr    r_out_hdr;
    logic [63:0]        r_out_data;
    logic [4:0]         r_out_fill;
    logic [15:0]        r_out_ovf;

    logic              w_in_acc;
    logic [2:0]        w_en_cnt;
    logic              w_scan_end;
    logic              w_hit;
    logic [FW-1:0]     w_fill_cur;
    logic [15:0]       w_ovf_cur;
    logic              w_full;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    crxmb_pkg::t_entry w_wdata;
    crxmb_pkg::t_entry w_rdata;
    logic              w_out_load;
    crxmb_pkg::t_hdr   w_in_hdr;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Clamp enabled count to the mailboxes and key registers present
    assign w_en_cnt   = (r_cfg_count > 3'(EN_MAX)) ? 3'(EN_MAX) : r_cfg_count;
    assign w_scan_end = (r_idx >= w_en_cnt);

    // Shared compare unit, one key per cycle
    crxmb_key_cmp u_cmp (
        .i_key (r_key[r_idx[1:0]]),
        .i_ide (r_hdr.ide),
        .i_id  (r_hdr.id),
        .o_hit (w_hit)
    );

    assign w_fill_cur = r_fill[r_mb];
    assign w_ovf_cur  = r_ovf[r_mb];
    assign w_full     = (w_fill_cur == FW'(QUEUE_DEPTH));
    assign w_mem_we   = (r_state == S_ACCESS) && (r_op == crxmb_pkg::OP_ROUTE) && !w_full;
    assign w_mem_re   = (r_state == S_ACCESS) && (r_op == crxmb_pkg::OP_READ) && r_mb_ok
                        && (w_fill_cur != '0);
    assign w_waddr    = AW'(32'(r_mb) * QUEUE_DEPTH + 32'(r_wp[r_mb]));
    assign w_raddr    = AW'(32'(r_mb) * QUEUE_DEPTH + 32'(r_rp[r_mb]));
    assign w_wdata    = '{hdr: r_hdr, data: r_data};

    crxmb_fifo_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Keep only the low 11 identifier bits of a standard frame
    always_comb begin
        w_in_hdr.ide = i_frame_ide;
        w_in_hdr.rtr = i_frame_rtr;
        w_in_hdr.dlc = i_frame_dlc;
        if (i_frame_ide) begin
            w_in_hdr.id = i_frame_id;
        end else begin
            w_in_hdr.id = {{(crxmb_pkg::ID_W - crxmb_pkg::STD_ID_W){1'b0}},
                           i_frame_id[crxmb_pkg::STD_ID_W-1:0]};
        end
    end

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_opcode == crxmb_pkg::OP_READ) ? S_ACCESS : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_DONE;
                end else if (w_hit) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
            for (int k = 0; k < crxmb_pkg::KEY_REGS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crxmb_pkg::CFG_COUNT: r_cfg_count <= i_cfg_data[2:0];
                crxmb_pkg::CFG_KEY0:  r_key[0] <= i_cfg_data;
                crxmb_pkg::CFG_KEY1:  r_key[1] <= i_cfg_data;
                crxmb_pkg::CFG_KEY2:  r_key[2] <= i_cfg_data;
                crxmb_pkg::CFG_KEY3:  r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the item, scan keys and build the result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_opcode;
            r_rmb   <= i_read_mailbox;
            r_mb_ok <= (32'(i_read_mailbox) < MAILBOXES);
            r_hdr   <= w_in_hdr;
            r_data  <= i_frame_data;
            r_idx   <= '0;
            r_mb    <= MB_W'(i_read_mailbox);
        end
        if (r_state == S_SCAN) begin
            if (w_scan_end) begin
                r_res_status <= crxmb_pkg::ST_NO_MATCH;
                r_res_mbi    <= '0;
                r_res_fill   <= '0;
                r_res_ovf    <= '0;
            end else if (w_hit) begin
                r_mb <= MB_W'(r_idx);
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
        if (r_state == S_ACCESS) begin
            if (r_op == crxmb_pkg::OP_ROUTE) begin
                r_res_mbi <= r_idx[1:0];
                if (w_full) begin
                    r_res_status <= crxmb_pkg::ST_FULL;
                    r_res_fill   <= w_fill_cur;
                    r_res_ovf    <= (w_ovf_cur == 16'hFFFF) ? w_ovf_cur : w_ovf_cur + 16'd1;
                end else begin
                    r_res_status <= crxmb_pkg::ST_STORED;
                    r_res_fill   <= w_fill_cur + FW'(1);
                    r_res_ovf    <= w_ovf_cur;
                end
            end else begin
                r_res_mbi <= r_rmb;
                if (w_mem_re) begin
                    r_res_status <= crxmb_pkg::ST_READ_OK;
                    r_res_fill   <= w_fill_cur - FW'(1);
                    r_res_ovf    <= w_ovf_cur;
                end else begin
                    r_res_status <= crxmb_pkg::ST_EMPTY;
                    r_res_fill   <= '0;
                    r_res_ovf    <= r_mb_ok ? w_ovf_cur : 16'd0;
                end
            end
        end
    end

    // Advance pointers, fill and overflow counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAILBOXES; k++) begin
                r_rp[k]   <= '0;
                r_wp[k]   <= '0;
                r_fill[k] <= '0;
                r_ovf[k]  <= '0;
            end
        end else if (r_state == S_ACCESS) begin
            if (w_mem_we) begin
                r_wp[r_mb]   <= (r_wp[r_mb] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_wp[r_mb] + QW'(1);
                r_fill[r_mb] <= w_fill_cur + FW'(1);
            end else if (w_mem_re) begin
                r_rp[r_mb]   <= (r_rp[r_mb] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_rp[r_mb] + QW'(1);
                r_fill[r_mb] <= w_fill_cur - FW'(1);
            end else if ((r_op == crxmb_pkg::OP_ROUTE) && (w_ovf_cur != 16'hFFFF)) begin
                r_ovf[r_mb]  <= w_ovf_cur + 16'd1;
            end
        end
    end

    // Output register: hold a beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_mbi    <= r_res_mbi;
            r_out_fill   <= 5'(r_res_fill);
            r_out_ovf    <= r_res_ovf;
            if (r_res_status == crxmb_pkg::ST_READ_OK) begin
                r_out_hdr  <= w_rdata.hdr;
                r_out_data <= w_rdata.data;
            end else begin
                r_out_hdr  <= '0;
                r_out_data <= '0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_mailbox_index  = r_out_mbi;
    assign o_out_ide        = r_out_hdr.ide;
    assign o_out_id         = r_out_hdr.id;
    assign o_out_rtr        = r_out_hdr.rtr;
    assign o_out_dlc        = r_out_hdr.dlc;
    assign o_out_data       = r_out_data;
    assign o_fill_level     = r_out_fill;
    assign o_overflow_count = r_out_ovf;

endmodule

/* hdl/crxmb_key_cmp.sv */
`timescale 1ns / 1ps

module crxmb_key_cmp (
    input  logic [crxmb_pkg::KEY_W-1:0] i_key,
    input  logic                        i_ide,
    input  logic [crxmb_pkg::ID_W-1:0]  i_id,
    output logic                        o_hit
);

    logic w_fmt_eq;
    logic w_ext_eq;
    logic w_std_eq;

    // Compare format flag, then the full or the standard identifier
    assign w_fmt_eq = (i_key[crxmb_pkg::KEY_W-1] == i_ide);
    assign w_ext_eq = (i_key[crxmb_pkg::ID_W-1:0] == i_id);
    assign w_std_eq = (i_key[crxmb_pkg::STD_ID_W-1:0] == i_id[crxmb_pkg::STD_ID_W-1:0]);
    assign o_hit    = w_fmt_eq && (i_ide ? w_ext_eq : w_std_eq);

endmodule

/* hdl/crxmb_fifo_mem.sv */
`timescale 1ns / 1ps

module crxmb_fifo_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  crxmb_pkg::t_entry       i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output crxmb_pkg::t_entry       o_rdata
);

    crxmb_pkg::t_entry r_mem [DEPTH];
    crxmb_pkg::t_entry r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, hold it until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/crxmb_checker.sv */
`timescale 1ns / 1ps

module crxmb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  o_status,
    input  logic [1:0]  o_mailbox_index,
    input  logic [28:0] o_out_id,
    input  logic [63:0] o_out_data,
    input  logic [4:0]  o_fill_level,
    input  logic [15:0] o_overflow_count
);

    // Block turns busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_out_data) && $stable(o_fill_level))
        else $error("stalled output beat changed");

    // Only a successful read carries frame contents
    a_no_frame_unless_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != crxmb_pkg::ST_READ_OK)
            |-> (o_out_data == 64'd0) && (o_out_id == 29'd0))
        else $error("frame contents on a non-read result");

    // An unmatched frame reports no mailbox state
    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == crxmb_pkg::ST_NO_MATCH)
            |-> (o_mailbox_index == 2'd0) && (o_fill_level == 5'd0)
                && (o_overflow_count == 16'd0))
        else $error("no-match result carries mailbox state");

endmodule

bind can_rx_id_router_mailbox_fifo_top crxmb_checker u_crxmb_checker (.*);
